@@ sv/i64dm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i64dm_pkg
// Shared constants and types of the 64-bit integer divider.
// ----------------------------------------------------------------------------
package i64dm_pkg;

  // Width of every operand and result field on the stream ports.
  localparam int unsigned FieldW = 64;
  // Default operand width that the divider actually works on.
  localparam int unsigned DataWidthDef = 64;

  // Status that the shift-subtract unit reports to its sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } i64dm_stat_t;

endpackage : i64dm_pkg
`default_nettype wire

@@ sv/i64dm_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i64dm_core
// Restoring shift-subtract divider for unsigned operands, one quotient bit
// per clock cycle.
// ----------------------------------------------------------------------------
module i64dm_core
  import i64dm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DATA_WIDTH-1:0] dividend_i,
  input  wire logic [DATA_WIDTH-1:0] divisor_i,
  output i64dm_stat_t                stat_o,
  output logic      [DATA_WIDTH-1:0] quotient_o,
  output logic      [DATA_WIDTH-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH + 1);

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] div_q, div_d;
  logic [DATA_WIDTH:0]   partial;
  logic [DATA_WIDTH+1:0] diff;
  logic                  borrow;

  assign partial = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff    = {1'b0, partial} - {2'b00, div_q};
  assign borrow  = diff[DATA_WIDTH+1];

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      cnt_d  = CntW'(DATA_WIDTH);
      busy_d = 1'b1;
      done_d = 1'b0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = borrow ? partial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
      quo_d = {quo_q[DATA_WIDTH-2:0], ~borrow};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule : i64dm_core
`default_nettype wire

@@ sv/int64_divide_modulo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int64_divide_modulo
// Signed and unsigned integer divider giving quotient and remainder.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. The sequencer first forms the
// magnitudes and starts the shift-subtract unit, which yields one quotient
// bit per cycle; it then sees that unit finish and, once the output register
// is free, restores the signs. A zero divisor skips the shift-subtract unit.
// The input is not ready while an item is in work, so the block takes no new
// item before the last one has reached the output register, where the
// finished result sits.
// Signed mode truncates toward zero and gives the remainder the sign of the
// dividend. A zero divisor sets the flag, returns all ones as the quotient
// and the dividend as the remainder. Input bits at and above DATA_WIDTH are
// ignored and result bits there are zero.
module int64_divide_modulo
  import i64dm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [63:0] dividend_in, [127:64] divisor_in
  input  wire logic [2*FieldW-1:0] s_axis_tdata_i,
  // [0] is_signed
  input  wire logic [0:0]          s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [63:0] quotient_res, [127:64] remainder_res
  output logic      [2*FieldW-1:0] m_axis_tdata_o,
  // [0] zero_divisor
  output logic      [0:0]          m_axis_tuser_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_FIX  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [DATA_WIDTH-1:0] a_q, a_d;
  logic [DATA_WIDTH-1:0] b_q, b_d;
  logic                  sgn_q, sgn_d;
  logic                  zero_q, zero_d;
  logic                  neg_quo_q, neg_quo_d;
  logic                  neg_rem_q, neg_rem_d;
  logic                  out_vld_q, out_vld_d;
  logic [FieldW-1:0]     out_quo_q, out_quo_d;
  logic [FieldW-1:0]     out_rem_q, out_rem_d;
  logic                  out_zero_q, out_zero_d;

  logic                  in_xfer;
  logic                  a_neg, b_neg;
  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic                  core_start;
  i64dm_stat_t           core_stat;
  logic [DATA_WIDTH-1:0] core_quo, core_rem;
  logic [DATA_WIDTH-1:0] fix_quo, fix_rem;
  logic                  out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_vld_q | m_axis_tready_i;

  assign a_neg = sgn_q & a_q[DATA_WIDTH-1];
  assign b_neg = sgn_q & b_q[DATA_WIDTH-1];
  assign mag_a = a_neg ? (~a_q + DATA_WIDTH'(1)) : a_q;
  assign mag_b = b_neg ? (~b_q + DATA_WIDTH'(1)) : b_q;

  assign fix_quo = zero_q ? '1 :
                   (neg_quo_q ? (~core_quo + DATA_WIDTH'(1)) : core_quo);
  assign fix_rem = zero_q ? a_q :
                   (neg_rem_q ? (~core_rem + DATA_WIDTH'(1)) : core_rem);

  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    b_d        = b_q;
    sgn_d      = sgn_q;
    zero_d     = zero_q;
    neg_quo_d  = neg_quo_q;
    neg_rem_d  = neg_rem_q;
    out_vld_d  = out_vld_q & ~m_axis_tready_i;
    out_quo_d  = out_quo_q;
    out_rem_d  = out_rem_q;
    out_zero_d = out_zero_q;
    core_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          a_d     = s_axis_tdata_i[DATA_WIDTH-1:0];
          b_d     = s_axis_tdata_i[FieldW+DATA_WIDTH-1:FieldW];
          sgn_d   = s_axis_tuser_i[0];
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        zero_d    = (b_q == '0);
        neg_quo_d = a_neg ^ b_neg;
        neg_rem_d = a_neg;
        if (b_q == '0) begin
          state_d = S_FIX;
        end else begin
          core_start = 1'b1;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        if (core_stat.done) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_quo_d  = FieldW'(fix_quo);
          out_rem_d  = FieldW'(fix_rem);
          out_zero_d = zero_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    sgn_q      <= sgn_d;
    zero_q     <= zero_d;
    neg_quo_q  <= neg_quo_d;
    neg_rem_q  <= neg_rem_d;
    out_quo_q  <= out_quo_d;
    out_rem_q  <= out_rem_d;
    out_zero_q <= out_zero_d;
  end

  i64dm_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (core_start),
    .dividend_i (mag_a),
    .divisor_i  (mag_b),
    .stat_o     (core_stat),
    .quotient_o (core_quo),
    .remainder_o(core_rem)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_rem_q, out_quo_q};
  assign m_axis_tuser_o  = out_zero_q;

  a_zero_quo_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (m_axis_tdata_o[DATA_WIDTH-1:0] == {DATA_WIDTH{1'b1}}))
    else $error("zero divisor result without all-ones quotient");

  a_core_idle_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !core_stat.busy)
    else $error("divider unit busy while input is ready");

  a_run_has_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (core_stat.busy || core_stat.done))
    else $error("sequencer waits on an idle divider unit");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIX && out_free) |=> (m_axis_tvalid_o && s_axis_tready_o))
    else $error("finished item not placed in output register");

endmodule : int64_divide_modulo
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the signed and unsigned 64-bit divider.
// A short table of corner divisions runs first. Rows with an obvious answer
// carry it typed in, and the rest are checked against a behavioral divider.
// About two thousand random divisions follow, drawn from mixed magnitudes,
// corner values and zero divisors. Both stream sides idle at random, with a
// long output hold-off and a few drain pauses on the input.
// ----------------------------------------------------------------------------
module testbench;
  import i64dm_pkg::*;

  localparam int unsigned DW = DataWidthDef;
  localparam int unsigned RandOps = 2000;
  localparam logic [63:0] Ones = {64{1'b1}};
  localparam logic [63:0] SMin = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SMax = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic        sgn;
  } div_op_t;

  typedef struct packed {
    logic [63:0] quotient;
    logic [63:0] remainder;
    logic        zero_div;
  } div_res_t;

  typedef struct packed {
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic        sgn;
    logic        typed;
    logic [63:0] quotient;
    logic [63:0] remainder;
    logic        zero_div;
  } div_row_t;

  // Rows with typed set carry their answer; the others use the predictor.
  div_row_t corner_rows [22] = '{
    '{64'd0, 64'd0, 1'b0, 1'b1, Ones, 64'd0, 1'b1},
    '{SMax, 64'd0, 1'b1, 1'b1, Ones, SMax, 1'b1},
    '{SMin, 64'd0, 1'b1, 1'b1, Ones, SMin, 1'b1},
    '{Ones, 64'd0, 1'b0, 1'b1, Ones, Ones, 1'b1},
    '{Ones, 64'd1, 1'b0, 1'b1, Ones, 64'd0, 1'b0},
    '{Ones, Ones, 1'b0, 1'b1, 64'd1, 64'd0, 1'b0},
    '{SMin, Ones, 1'b1, 1'b1, SMin, 64'd0, 1'b0},
    '{SMin, Ones, 1'b0, 1'b1, 64'd0, SMin, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 1'b1, 1'b1,
      64'hFFFF_FFFF_FFFF_FFFD, Ones, 1'b0},
    '{64'd7, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1,
      64'hFFFF_FFFF_FFFF_FFFD, 64'd1, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFF9, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1,
      64'd3, Ones, 1'b0},
    '{64'd7, 64'd2, 1'b0, 1'b1, 64'd3, 64'd1, 1'b0},
    '{SMin, 64'd1, 1'b1, 1'b0, 64'd0, 64'd0, 1'b0},
    '{SMax, SMin, 1'b1, 1'b0, 64'd0, 64'd0, 1'b0},
    '{SMin, SMin, 1'b1, 1'b0, 64'd0, 64'd0, 1'b0},
    '{64'd0, Ones, 1'b1, 1'b0, 64'd0, 64'd0, 1'b0},
    '{Ones, Ones, 1'b1, 1'b0, 64'd0, 64'd0, 1'b0},
    '{64'h0123_4567_89AB_CDEF, 64'h0000_0000_0000_FFFF, 1'b0, 1'b0,
      64'd0, 64'd0, 1'b0},
    '{64'hFEDC_BA98_7654_3210, 64'h0000_0000_8000_0000, 1'b1, 1'b0,
      64'd0, 64'd0, 1'b0},
    '{64'h0000_0000_0001_0000, 64'h0000_0000_0000_FFFF, 1'b0, 1'b0,
      64'd0, 64'd0, 1'b0},
    '{Ones, 64'd1, 1'b1, 1'b0, 64'd0, 64'd0, 1'b0},
    '{64'd1, Ones, 1'b0, 1'b0, 64'd0, 64'd0, 1'b0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_axis_tready;
  // [63:0] dividend_in, [127:64] divisor_in
  logic [2*FieldW-1:0] s_data = '0;
  // [0] is_signed
  logic [0:0]          s_user = '0;
  logic                m_axis_tvalid;
  logic                m_ready = 1'b0;
  // [63:0] quotient_res, [127:64] remainder_res
  logic [2*FieldW-1:0] m_axis_tdata;
  // [0] zero_divisor
  logic [0:0]          m_axis_tuser;

  div_res_t pending_divmod [$];
  int unsigned mismatches = 0;

  int64_divide_modulo #(
    .DATA_WIDTH(DW)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] twos_neg(input logic [63:0] v, input logic [63:0] mask);
    return (~v + 64'd1) & mask;
  endfunction

  function automatic div_res_t divmod_predict(input div_op_t op);
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] q;
    logic [63:0] r;
    logic        neg_a;
    logic        neg_b;
    div_res_t    res;
    mask = Ones >> (64 - DW);
    a = op.dividend & mask;
    b = op.divisor & mask;
    if (b == 64'd0) begin
      res.quotient = mask;
      res.remainder = a;
      res.zero_div = 1'b1;
      return res;
    end
    neg_a = op.sgn & a[DW-1];
    neg_b = op.sgn & b[DW-1];
    mag_a = neg_a ? twos_neg(a, mask) : a;
    mag_b = neg_b ? twos_neg(b, mask) : b;
    q = mag_a / mag_b;
    r = mag_a % mag_b;
    if (neg_a != neg_b) q = twos_neg(q, mask);
    if (neg_a) r = twos_neg(r, mask);
    res.quotient = q & mask;
    res.remainder = r & mask;
    res.zero_div = 1'b0;
    return res;
  endfunction

  function automatic logic [63:0] draw_operand();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 64'd0;
          1: v = 64'd1;
          2: v = Ones;
          3: v = SMin;
          default: v = SMax;
        endcase
      end
      1, 2, 3: begin
        v = {$urandom, $urandom};
      end
      default: begin
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 1) == 1) v = ~v + 64'd1;
      end
    endcase
    return v;
  endfunction

  task automatic offer_op(input div_op_t op, input div_res_t want, input int unsigned gap);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {op.divisor, op.dividend};
    s_user <= op.sgn;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_divmod.push_back(want);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) $display("Mismatch in %s: expected %h, got %h", what, want, got);
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (pending_divmod.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    div_res_t want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      if (pending_divmod.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transfer: tdata %h tuser %b",
                                       m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_divmod.pop_front();
        if (m_axis_tdata[63:0] !== want.quotient)
          note_mismatch("quotient", want.quotient, m_axis_tdata[63:0]);
        if (m_axis_tdata[127:64] !== want.remainder)
          note_mismatch("remainder", want.remainder, m_axis_tdata[127:64]);
        if (m_axis_tuser[0] !== want.zero_div)
          note_mismatch("zero divisor flag", 64'(want.zero_div), 64'(m_axis_tuser[0]));
      end
    end
  end

  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          calm;
    taken = 0;
    calm = 1'b0;
    wait (rst_ni);
    forever begin
      if (taken % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 9);
      if (taken == 60) stall = 400;
      if (stall != 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
    end
  end

  initial begin
    div_op_t  op;
    div_res_t want;
    bit       burst;
    burst = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (corner_rows[i]) begin
      op.dividend = corner_rows[i].dividend;
      op.divisor = corner_rows[i].divisor;
      op.sgn = corner_rows[i].sgn;
      if (corner_rows[i].typed) begin
        want.quotient = corner_rows[i].quotient;
        want.remainder = corner_rows[i].remainder;
        want.zero_div = corner_rows[i].zero_div;
      end else begin
        want = divmod_predict(op);
      end
      offer_op(op, want, $urandom_range(0, 9));
    end
    drain_results();
    for (int n = 0; n < RandOps; n++) begin
      if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == RandOps / 2) drain_results();
      op.dividend = draw_operand();
      op.divisor = ($urandom_range(0, 31) == 0) ? 64'd0 : draw_operand();
      op.sgn = 1'($urandom_range(0, 1));
      offer_op(op, divmod_predict(op), burst ? 0 : $urandom_range(0, 9));
    end
    s_valid <= 1'b0;
    while (pending_divmod.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_divmod.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule : testbench
`default_nettype wire
